FILE: src/u8u16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT = 16'hFFFD;
    localparam logic [20:0] CP_MAX    = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE = 21'h010000;
    localparam logic [20:0] MIN_CP3   = 21'h000800;
    localparam logic [20:0] MIN_CP2   = 21'h000080;
    localparam logic [15:0] HI_SURR   = 16'hD800;
    localparam logic [15:0] LO_SURR   = 16'hDC00;

    // One input byte of the string
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_word_t;

    // One UTF-16 result
    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        run_last;
        logic        string_end;
    } out_word_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
    } unit_t;

    // All units caused by one byte, oldest in slot 0
    typedef struct packed {
        unit_t [3:0] units;
        logic  [2:0] count;
        logic        fin;
    } run_t;

endpackage

FILE: src/u8u16_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence state and single-pass decode of one byte into a run of units.
// ----------------------------------------------------------------------------
module u8u16_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  u8u16_pkg::in_word_t word,
    output u8u16_pkg::run_t     run
);

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [2:0] len_reg;
    logic [2:0] len_next;
    logic [7:0] pb_reg [0:2];

    logic        pb_we;
    logic [1:0]  pb_idx;
    logic [7:0]  b;
    logic        fin;
    logic        pending;
    logic        is_cont;
    logic        complete;
    logic [2:0]  lead_len;
    logic [20:0] cp;
    logic [20:0] v;
    logic        ok;
    logic [1:0]  rep_cnt;
    logic [1:0]  tail_cnt;
    u8u16_pkg::unit_t t0;
    u8u16_pkg::unit_t t1;
    logic [2:0]  slot;
    logic [2:0]  off;

    always_comb
    begin
        b        = word.data_byte;
        fin      = word.final_byte;
        pending  = (cnt_reg != 2'd0);
        is_cont  = (b[7:6] == 2'b10);
        complete = (({1'b0, cnt_reg} + 3'd1) == len_reg);

        if (b[7:5] == 3'b110)
            lead_len = LEN_2;
        else if (b[7:4] == 4'b1110)
            lead_len = LEN_3;
        else if (b[7:3] == 5'b11110)
            lead_len = LEN_4;
        else
            lead_len = LEN_NONE;

        // the byte that completes a sequence is always the current one
        unique case (len_reg)
            LEN_2:
            begin
                cp = {10'd0, pb_reg[0][4:0], b[5:0]};
                ok = (cp >= u8u16_pkg::MIN_CP2);
            end
            LEN_3:
            begin
                cp = {5'd0, pb_reg[0][3:0], pb_reg[1][5:0], b[5:0]};
                ok = (cp >= u8u16_pkg::MIN_CP3);
            end
            default:
            begin
                cp = {pb_reg[0][2:0], pb_reg[1][5:0], pb_reg[2][5:0], b[5:0]};
                ok = (cp >= u8u16_pkg::SUPP_BASE) && (cp <= u8u16_pkg::CP_MAX);
            end
        endcase
        v = cp - u8u16_pkg::SUPP_BASE;

        rep_cnt  = 2'd0;
        tail_cnt = 2'd0;
        t0       = '{code_unit: u8u16_pkg::REPL_UNIT, replaced: 1'b1};
        t1       = '{code_unit: u8u16_pkg::LO_SURR | {6'd0, v[9:0]}, replaced: 1'b0};
        cnt_next = cnt_reg;
        len_next = len_reg;
        pb_we    = 1'b0;
        pb_idx   = cnt_reg;

        if (pending && is_cont)
        begin
            if (complete)
            begin
                tail_cnt = 2'd1;
                cnt_next = 2'd0;
                len_next = LEN_NONE;
                if (ok && (len_reg == LEN_2 || len_reg == LEN_3))
                    t0 = '{code_unit: cp[15:0], replaced: 1'b0};
                else if (ok)
                begin
                    t0 = '{code_unit: u8u16_pkg::HI_SURR | {6'd0, v[19:10]},
                           replaced: 1'b0};
                    tail_cnt = 2'd2;
                end
            end
            else if (fin)
            begin
                // cut off: one replacement per byte held, this one included
                rep_cnt  = cnt_reg + 2'd1;
                cnt_next = 2'd0;
                len_next = LEN_NONE;
            end
            else
            begin
                pb_we    = 1'b1;
                cnt_next = cnt_reg + 2'd1;
            end
        end
        else
        begin
            // drop any broken sequence, then start afresh with this byte
            rep_cnt  = cnt_reg;
            cnt_next = 2'd0;
            len_next = LEN_NONE;
            if (!b[7])
            begin
                t0       = '{code_unit: {8'd0, b}, replaced: 1'b0};
                tail_cnt = 2'd1;
            end
            else if (lead_len != LEN_NONE)
            begin
                pb_we  = 1'b1;
                pb_idx = 2'd0;
                if (fin)
                    tail_cnt = 2'd1;
                else
                begin
                    cnt_next = 2'd1;
                    len_next = lead_len;
                end
            end
            else
                tail_cnt = 2'd1;
        end

        run.count = {1'b0, rep_cnt} + {1'b0, tail_cnt};
        run.fin   = fin;
        for (int i = 0; i < 4; i++)
        begin
            slot = 3'(i);
            off  = slot - {1'b0, rep_cnt};
            if (slot < {1'b0, rep_cnt})
                run.units[i] = '{code_unit: u8u16_pkg::REPL_UNIT, replaced: 1'b1};
            else if (off == 3'd0)
                run.units[i] = t0;
            else
                run.units[i] = t1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            len_reg <= LEN_NONE;
        end
        else if (advance)
        begin
            cnt_reg <= cnt_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pb_we)
            pb_reg[pb_idx] <= b;
    end

`ifndef SYNTHESIS
    a_pending_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd0) |-> ({1'b0, cnt_reg} < len_reg))
        else $error("pending byte count not below sequence length");
`endif

endmodule

FILE: src/u8u16_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_serializer
// Holds one run of units and hands them out one word per handshake.
// ----------------------------------------------------------------------------
module u8u16_serializer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  u8u16_pkg::run_t      run,
    output logic                 ready,
    output logic                 unit_valid,
    input  logic                 unit_stall,
    output u8u16_pkg::out_word_t unit_word
);

    u8u16_pkg::run_t run_reg;
    logic            busy_reg;
    logic [1:0]      idx_reg;
    logic            take;
    logic            last;

    assign take  = busy_reg && !unit_stall;
    assign last  = ({1'b0, idx_reg} == (run_reg.count - 3'd1));
    assign ready = !busy_reg || (take && last);

    assign unit_valid           = busy_reg;
    assign unit_word.code_unit  = run_reg.units[idx_reg].code_unit;
    assign unit_word.replaced   = run_reg.units[idx_reg].replaced;
    assign unit_word.run_last   = last;
    assign unit_word.string_end = last && run_reg.fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load && ready)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (take)
        begin
            if (last)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
            run_reg <= run;
    end

`ifndef SYNTHESIS
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (run_reg.count != 3'd0 && run_reg.count <= 3'd4))
        else $error("held run has no units or too many");

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, idx_reg} < run_reg.count))
        else $error("unit index past end of run");

    a_idx_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last && !load) |=> (busy_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("unit index did not advance after a taken word");
`endif

endmodule

FILE: src/utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps
// A byte accepted into the input register is decoded combinationally; its run is loaded into
//   the serializer's run register, which offers the first unit on the unit port.
// One byte per cycle while each byte yields at most one unit and the receiver does not stall;
//   a byte with more units (up to four) sends them in turn and stalls the next byte with units.
// Bytes that only extend a pending sequence yield nothing and pass at one per cycle.
// Reset (rst_n low, asynchronous) empties both registers and closes any open sequence.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streaming UTF-8 to UTF-16 converter with U+FFFD replacement of bad input.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  u8u16_pkg::in_word_t  byte_word,
    output logic                 unit_valid,
    input  logic                 unit_stall,
    output u8u16_pkg::out_word_t unit_word
);

    u8u16_pkg::in_word_t in_reg;
    logic                in_valid_reg;
    u8u16_pkg::run_t     run;
    logic                ser_ready;
    logic                consume;

    // a byte with no units retires without waiting on the run register
    assign consume    = in_valid_reg && ((run.count == 3'd0) || ser_ready);
    assign byte_stall = in_valid_reg && !consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!byte_stall)
            in_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
            in_reg <= byte_word;
    end

    u8u16_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (consume),
        .word    (in_reg),
        .run     (run)
    );

    u8u16_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (consume && (run.count != 3'd0)),
        .run        (run),
        .ready      (ser_ready),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_word  (unit_word)
    );

endmodule

FILE: tb/tb_utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder
// Feeds UTF-8 strings byte by byte through the transcoder and checks each
// UTF-16 word against a decoder kept in step with the accepted bytes.
// Directed edge cases come first, then random well-formed and broken text,
// with random gaps and stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder;

    localparam int unsigned RANDOM_BYTES = 346;
    localparam int unsigned IDLE_LIMIT   = 3000;
    localparam int unsigned HOLD_CYCLES  = 200;

    class utf16_scoreboard;
        logic [7:0]  seq_bytes [4];
        int unsigned seq_fill;
        int unsigned seq_len;
        u8u16_pkg::out_word_t run_units [$];
        u8u16_pkg::out_word_t units_due [$];
        int unsigned units_seen;
        int unsigned mismatches;

        function void add_unit(logic [15:0] unit, logic repl);
            u8u16_pkg::out_word_t w;
            w.code_unit  = unit;
            w.replaced   = repl;
            w.run_last   = 1'b0;
            w.string_end = 1'b0;
            run_units.push_back(w);
        endfunction

        function void start_lead(logic [7:0] b);
            int unsigned len;
            len = 0;
            if (b[7] == 1'b0)
            begin
                add_unit({8'h00, b}, 1'b0);
                return;
            end
            if (b[7:5] == 3'b110)
                len = 2;
            else if (b[7:4] == 4'b1110)
                len = 3;
            else if (b[7:3] == 5'b11110)
                len = 4;
            if (len == 0)
            begin
                add_unit(u8u16_pkg::REPL_UNIT, 1'b1);
                return;
            end
            seq_bytes[0] = b;
            seq_fill = 1;
            seq_len = len;
        endfunction

        function void close_sequence();
            logic [20:0] cp;
            logic [20:0] offs;
            logic        ok;
            if (seq_len == 2)
            begin
                cp = {10'd0, seq_bytes[0][4:0], seq_bytes[1][5:0]};
                ok = (cp >= u8u16_pkg::MIN_CP2);
            end
            else if (seq_len == 3)
            begin
                cp = {5'd0, seq_bytes[0][3:0], seq_bytes[1][5:0], seq_bytes[2][5:0]};
                ok = (cp >= u8u16_pkg::MIN_CP3);
            end
            else
            begin
                cp = {seq_bytes[0][2:0], seq_bytes[1][5:0], seq_bytes[2][5:0],
                      seq_bytes[3][5:0]};
                ok = (cp >= u8u16_pkg::SUPP_BASE) && (cp <= u8u16_pkg::CP_MAX);
            end
            if (!ok)
                add_unit(u8u16_pkg::REPL_UNIT, 1'b1);
            else if (cp < u8u16_pkg::SUPP_BASE)
                add_unit(cp[15:0], 1'b0);
            else
            begin
                offs = cp - u8u16_pkg::SUPP_BASE;
                add_unit(u8u16_pkg::HI_SURR | {6'd0, offs[19:10]}, 1'b0);
                add_unit(u8u16_pkg::LO_SURR | {6'd0, offs[9:0]}, 1'b0);
            end
        endfunction

        // one replacement per buffered byte, lead included
        function void flush_held();
            for (int i = 0; i < seq_fill; i++)
                add_unit(u8u16_pkg::REPL_UNIT, 1'b1);
            seq_fill = 0;
            seq_len = 0;
        endfunction

        function void take_byte(u8u16_pkg::in_word_t w);
            logic [7:0] b;
            b = w.data_byte;
            run_units.delete();
            if (seq_fill != 0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    seq_bytes[seq_fill[1:0]] = b;
                    seq_fill++;
                    if (seq_fill >= seq_len)
                    begin
                        close_sequence();
                        seq_fill = 0;
                        seq_len = 0;
                    end
                end
                else
                begin
                    flush_held();
                    start_lead(b);
                end
            end
            else
                start_lead(b);
            if (w.final_byte && seq_fill != 0)
                flush_held();
            if (run_units.size() > 0)
            begin
                run_units[run_units.size() - 1].run_last = 1'b1;
                run_units[run_units.size() - 1].string_end = w.final_byte;
            end
            foreach (run_units[i])
                units_due.push_back(run_units[i]);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("ERROR word %0d %s: got %h, expected %h", units_seen, what, got, want);
            mismatches++;
        endtask

        task check_unit(u8u16_pkg::out_word_t w);
            u8u16_pkg::out_word_t want;
            if (units_due.size() == 0)
                report_mismatch("unexpected word", 32'(w), 32'd0);
            else
            begin
                want = units_due.pop_front();
                if (w.code_unit !== want.code_unit)
                    report_mismatch("code_unit", 32'(w.code_unit), 32'(want.code_unit));
                if (w.replaced !== want.replaced)
                    report_mismatch("replaced", 32'(w.replaced), 32'(want.replaced));
                if (w.run_last !== want.run_last)
                    report_mismatch("run_last", 32'(w.run_last), 32'(want.run_last));
                if (w.string_end !== want.string_end)
                    report_mismatch("string_end", 32'(w.string_end), 32'(want.string_end));
            end
            units_seen++;
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 byte_valid;
    logic                 byte_stall;
    u8u16_pkg::in_word_t  byte_word;
    logic                 unit_valid;
    logic                 unit_stall;
    u8u16_pkg::out_word_t unit_word;

    utf16_scoreboard     sb;
    u8u16_pkg::in_word_t utf8_bytes [$];
    int unsigned         bytes_taken = 0;
    int unsigned         idle_cycles = 0;

    utf8_to_utf16_transcoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_word  (unit_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [20:0] pick_code_point(int unsigned len);
        case (len)
            1:       return 21'($urandom_range(0, 'h7F));
            2:       return 21'($urandom_range('h80, 'h7FF));
            3:       return 21'($urandom_range('h800, 'hFFFF));
            default: return 21'($urandom_range('h10000, 'h10FFFF));
        endcase
    endfunction

    task push_byte(logic [7:0] b, logic fin);
        u8u16_pkg::in_word_t w;
        w.data_byte = b;
        w.final_byte = fin;
        utf8_bytes.push_back(w);
    endtask

    // encode cp in exactly len bytes (overlong allowed), keep the first keep bytes
    task push_seq(logic [20:0] cp, int unsigned len, int unsigned keep, logic fin);
        logic [7:0] enc [4];
        case (len)
            1:
            begin
                enc[0] = {1'b0, cp[6:0]};
            end
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            push_byte(enc[i], fin && (i == keep - 1));
    endtask

    task build_directed();
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b1);
        push_byte(8'hC2, 1'b0);     // smallest two-byte form
        push_byte(8'h80, 1'b0);
        push_byte(8'hC1, 1'b0);     // overlong two-byte form
        push_byte(8'hBF, 1'b0);
        push_byte(8'hEF, 1'b0);     // genuine U+FFFD, not a replacement
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBD, 1'b0);
        push_byte(8'hF4, 1'b0);     // highest code point
        push_byte(8'h8F, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hF4, 1'b0);     // just above the highest code point
        push_byte(8'h90, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);     // bad lead
        push_byte(8'h80, 1'b0);     // lone continuation
        push_byte(8'hE2, 1'b0);     // broken by an ASCII byte
        push_byte(8'h82, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'hF0, 1'b0);     // cut off by the end of the string
        push_byte(8'h9F, 1'b1);
    endtask

    task build_random(int unsigned total);
        int unsigned kind;
        int unsigned len;
        int unsigned b;
        logic [20:0] cp;
        while (utf8_bytes.size() < total)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                len = (kind < 30) ? 1 : (kind < 50) ? 2 : (kind < 68) ? 3 : 4;
                push_seq(pick_code_point(len), len, len, $urandom_range(0, 9) == 0);
            end
            else if (kind < 85)
            begin
                // overlong: value below the minimum for the chosen length
                len = $urandom_range(2, 4);
                cp = (len == 2) ? 21'($urandom_range(0, 'h7F)) :
                     (len == 3) ? 21'($urandom_range(0, 'h7FF)) :
                                  21'($urandom_range(0, 'hFFFF));
                push_seq(cp, len, len, $urandom_range(0, 9) == 0);
            end
            else if (kind < 88)
                push_seq(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4,
                         $urandom_range(0, 9) == 0);
            else if (kind < 91)
            begin
                if ($urandom_range(0, 1) != 0)
                    push_byte(8'($urandom_range('hF8, 'hFF)), $urandom_range(0, 9) == 0);
                else
                    push_byte(8'($urandom_range('h80, 'hBF)), $urandom_range(0, 9) == 0);
            end
            else if (kind < 96)
            begin
                len = $urandom_range(2, 4);
                if ($urandom_range(0, 1) != 0)
                    push_seq(pick_code_point(len), len, $urandom_range(1, len - 1), 1'b1);
                else
                begin
                    push_seq(pick_code_point(len), len, $urandom_range(1, len - 1), 1'b0);
                    b = $urandom_range(0, 191);
                    if (b >= 128)
                        b = b + 64;
                    push_byte(8'(b), $urandom_range(0, 9) == 0);
                end
            end
            else
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 1) != 0);
        end
    endtask

    // offer one byte and hold it until the block takes it
    task drive_byte(u8u16_pkg::in_word_t w);
        byte_valid <= 1'b1;
        byte_word  <= w;
        do
            @(posedge clk);
        while (byte_stall);
        @(negedge clk);
    endtask

    // handshake monitor and idle counter for the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                sb.take_byte(byte_word);
                bytes_taken++;
            end
            if (unit_valid && !unit_stall)
                sb.check_unit(unit_word);
            if ((byte_valid && !byte_stall) || (unit_valid && !unit_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stalls, quiet stretches, and one long hold-off
    initial
    begin
        int unsigned hold;
        bit          held_off;
        held_off = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held_off && bytes_taken >= 150)
            begin
                held_off = 1;
                hold = HOLD_CYCLES;
            end
            else if ((sb.units_seen / 40) % 4 == 1)
                hold = 0;
            else
                hold = pick_gap();
            if (hold == 0)
                unit_stall <= 1'b0;
            else
            begin
                unit_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        int unsigned gap;
        sb = new();
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_word = '0;
        unit_stall = 1'b0;
        build_directed();
        build_random(utf8_bytes.size() + RANDOM_BYTES);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int i = 0; i < utf8_bytes.size(); i++)
        begin
            gap = ((i / 40) % 4 == 3) ? 0 : pick_gap();
            if (gap != 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            drive_byte(utf8_bytes[i]);
        end
        byte_valid <= 1'b0;
        while (sb.units_due.size() != 0)
            @(posedge clk);
        // catch stray words after the last expected one
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
src/u8u16_pkg.sv
src/u8u16_decode.sv
src/u8u16_serializer.sv
src/utf8_to_utf16_transcoder.sv
tb/tb_utf8_to_utf16_transcoder.sv
